// ===== hdl/dod_pkg.sv =====
// ----------------------------------------------------------------------------
// dod_pkg
// shared widths, constants, command codes and control structs for the
// differential drive odometry block
// ----------------------------------------------------------------------------
package dod_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int POSITION_BITS = 32;
    localparam int CORDIC_STEPS  = 16;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);

    // cordic vector and residual widths
    localparam int VEC_W = 34;
    localparam int ZW    = 33;

    // shared multiplier operand and product widths
    localparam int MA_W = 35;
    localparam int MB_W = 18;
    localparam int MP_W = MA_W + MB_W;
    localparam int ACC_W = 70;

    // position sum width, wide enough for a 32-bit clamp as well
    localparam int PSUM_W = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 1;

    localparam logic [15:0] TURN_GAIN_RESET = 16'd811;
    localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
    localparam logic signed [VEC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam int NUM_OPS = 10;
    localparam int IDX_W   = $clog2(NUM_OPS);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DL,   // left distance
        OP_DR,   // right distance
        OP_RL,   // speed difference times gain
        OP_TG,   // distance difference times gain
        OP_TL,   // turn times low part of 1/(2 pi)
        OP_TH,   // turn times high part, heading update
        OP_XL,   // mean times low half of cosine
        OP_XH,   // mean times high half of cosine, x update
        OP_YL,
        OP_YH
    } op_t;

    typedef struct packed {
        logic capture;
        op_t  op;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic out_free;
    } status_t;

    function automatic op_t op_at(input logic [IDX_W-1:0] idx);
        op_t o;
        case (idx)
            4'd0:    o = OP_DL;
            4'd1:    o = OP_DR;
            4'd2:    o = OP_RL;
            4'd3:    o = OP_TG;
            4'd4:    o = OP_TL;
            4'd5:    o = OP_TH;
            4'd6:    o = OP_XL;
            4'd7:    o = OP_XH;
            4'd8:    o = OP_YL;
            4'd9:    o = OP_YH;
            default: o = OP_NONE;
        endcase
        return o;
    endfunction

    function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] i);
        logic [31:0] a;
        case (i)
            4'd0:    a = 32'd536870912;
            4'd1:    a = 32'd316933406;
            4'd2:    a = 32'd167458907;
            4'd3:    a = 32'd85004756;
            4'd4:    a = 32'd42667331;
            4'd5:    a = 32'd21354465;
            4'd6:    a = 32'd10679838;
            4'd7:    a = 32'd5340245;
            4'd8:    a = 32'd2670163;
            4'd9:    a = 32'd1335087;
            4'd10:   a = 32'd667544;
            4'd11:   a = 32'd333772;
            4'd12:   a = 32'd166886;
            4'd13:   a = 32'd83443;
            4'd14:   a = 32'd41722;
            4'd15:   a = 32'd20861;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/dod_cordic.sv =====
// ----------------------------------------------------------------------------
// dod_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle, gives the
// cosine and sine of a binary angle in q2.30
// ----------------------------------------------------------------------------
module dod_cordic (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [dod_pkg::ANGLE_BITS-1:0]         angle,
    output logic                                   done,
    output logic signed [dod_pkg::VEC_W-1:0]       cos_val,
    output logic signed [dod_pkg::VEC_W-1:0]       sin_val
);

    localparam logic signed [dod_pkg::ZW-1:0] QUARTER = 33'sd1073741824;
    localparam logic signed [dod_pkg::ZW-1:0] HALF    = 33'sd2147483648;

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [dod_pkg::STEP_W-1:0]          step_reg, step_next;
    logic                                flip_reg, flip_next;
    logic signed [dod_pkg::VEC_W-1:0]    x_reg, x_next;
    logic signed [dod_pkg::VEC_W-1:0]    y_reg, y_next;
    logic signed [dod_pkg::ZW-1:0]       z_reg, z_next;

    logic [31:0]                         a32;
    logic signed [dod_pkg::ZW-1:0]       z0;
    logic signed [dod_pkg::VEC_W-1:0]    dx, dy;
    logic signed [dod_pkg::ZW-1:0]       at;

    assign a32 = {angle, {(32 - dod_pkg::ANGLE_BITS){1'b0}}};
    assign z0  = dod_pkg::ZW'($signed(a32));
    assign dx  = y_reg >>> step_reg;
    assign dy  = x_reg >>> step_reg;
    assign at  = $signed({1'b0, dod_pkg::atan_at(step_reg)});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            x_next    = dod_pkg::CORDIC_GAIN_Q30;
            y_next    = '0;
            // fold the outer half circles onto the convergent range
            if (z0 > QUARTER)
            begin
                z_next    = z0 - HALF;
                flip_next = 1'b1;
            end
            else if (z0 < -QUARTER)
            begin
                z_next    = z0 + HALF;
                flip_next = 1'b1;
            end
            else
            begin
                z_next    = z0;
                flip_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[dod_pkg::ZW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            if (step_reg == dod_pkg::STEP_W'(dod_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign done    = done_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;

endmodule

// ===== hdl/dod_datapath.sv =====
// ----------------------------------------------------------------------------
// dod_datapath
// input latches, shared multiplier with product register, accumulator,
// pose state, turn gain register and output registers
// ----------------------------------------------------------------------------
module dod_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dod_pkg::cmd_t                 cmd,
    output dod_pkg::status_t              status,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data,
    input  logic signed [15:0]            left_speed,
    input  logic signed [15:0]            right_speed,
    input  logic [15:0]                   tick_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            pos_x,
    output logic signed [31:0]            pos_y,
    output logic [15:0]                   heading,
    output logic signed [15:0]            linear_speed,
    output logic signed [23:0]            angular_speed
);

    localparam int PB = dod_pkg::POSITION_BITS;
    localparam int AB = dod_pkg::ANGLE_BITS;
    localparam int PW = dod_pkg::PSUM_W;

    localparam logic signed [PW-1:0] POS_MAX = {{(PW - PB + 1){1'b0}}, {(PB - 1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = ~POS_MAX;
    localparam logic signed [PW-1:0] O32_MAX = {{(PW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PW-1:0] O32_MIN = ~O32_MAX;
    localparam logic signed [26:0]   ANG_MAX = 27'sd8388607;
    localparam logic signed [26:0]   ANG_MIN = -27'sd8388608;

    logic [15:0]                          turn_gain_reg;
    logic signed [15:0]                   l_reg, r_reg;
    logic [15:0]                          dt_reg;
    logic signed [33:0]                   dl_reg, dr_reg;
    logic signed [34:0]                   rl_reg;
    logic signed [34:0]                   turn_reg;
    logic signed [dod_pkg::ACC_W-1:0]     acc_reg;
    logic signed [dod_pkg::MP_W-1:0]      prod_reg;
    dod_pkg::op_t                         wb_op_reg;
    logic signed [PB-1:0]                 x_reg, y_reg;
    logic [AB-1:0]                        heading_reg;
    logic                                 out_valid_reg;

    logic signed [dod_pkg::MA_W-1:0]      mul_a;
    logic signed [dod_pkg::MB_W-1:0]      mul_b;
    logic signed [dod_pkg::MP_W-1:0]      prod_next;
    logic signed [16:0]                   rl_diff;
    logic signed [16:0]                   lr_sum;
    logic signed [34:0]                   d_sum, d_diff;
    logic signed [33:0]                   mean;
    logic signed [dod_pkg::VEC_W-1:0]     cos_val, sin_val;
    logic                                 cordic_done;
    logic [47:0]                          turns48;
    logic signed [dod_pkg::ACC_W-1:0]     pos_prod;
    logic signed [31:0]                   delta;
    logic signed [PW-1:0]                 x_sum, y_sum;
    logic signed [PW-1:0]                 x_ext, y_ext;
    logic signed [26:0]                   ang_full;
    logic [AB+15:0]                       head_wide;

    function automatic logic signed [PB-1:0] clamp_pos(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        if (v > POS_MAX)
            c = POS_MAX;
        else if (v < POS_MIN)
            c = POS_MIN;
        else
            c = v;
        return c[PB-1:0];
    endfunction

    function automatic logic signed [31:0] clamp_32(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        if (v > O32_MAX)
            c = O32_MAX;
        else if (v < O32_MIN)
            c = O32_MIN;
        else
            c = v;
        return c[31:0];
    endfunction

    dod_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.capture),
        .angle   (heading_reg),
        .done    (cordic_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign rl_diff = 17'(r_reg) - 17'(l_reg);
    assign lr_sum  = 17'(r_reg) + 17'(l_reg);
    assign d_sum   = 35'(dl_reg) + 35'(dr_reg);
    assign d_diff  = 35'(dr_reg) - 35'(dl_reg);
    assign mean    = d_sum[34:1];

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            dod_pkg::OP_DL:
            begin
                mul_a = 35'(l_reg);
                mul_b = $signed({2'b00, dt_reg});
            end
            dod_pkg::OP_DR:
            begin
                mul_a = 35'(r_reg);
                mul_b = $signed({2'b00, dt_reg});
            end
            dod_pkg::OP_RL:
            begin
                mul_a = 35'(rl_diff);
                mul_b = $signed({2'b00, turn_gain_reg});
            end
            dod_pkg::OP_TG:
            begin
                mul_a = d_diff;
                mul_b = $signed({2'b00, turn_gain_reg});
            end
            dod_pkg::OP_TL:
            begin
                mul_a = turn_reg;
                mul_b = $signed({3'b000, dod_pkg::INV_TWO_PI_Q32[14:0]});
            end
            dod_pkg::OP_TH:
            begin
                mul_a = turn_reg;
                mul_b = $signed({3'b000, dod_pkg::INV_TWO_PI_Q32[29:15]});
            end
            dod_pkg::OP_XL:
            begin
                mul_a = 35'(mean);
                mul_b = $signed({2'b00, cos_val[15:0]});
            end
            dod_pkg::OP_XH:
            begin
                mul_a = 35'(mean);
                mul_b = cos_val[33:16];
            end
            dod_pkg::OP_YL:
            begin
                mul_a = 35'(mean);
                mul_b = $signed({2'b00, sin_val[15:0]});
            end
            dod_pkg::OP_YH:
            begin
                mul_a = 35'(mean);
                mul_b = sin_val[33:16];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // writeback helpers, fed by the registered product
    assign turns48  = acc_reg[47:0] + {prod_reg[32:0], 15'b0};
    assign pos_prod = acc_reg + (dod_pkg::ACC_W'(prod_reg) <<< 16);
    assign delta    = pos_prod[69:38];
    assign x_sum    = PW'(x_reg) + PW'(delta);
    assign y_sum    = PW'(y_reg) + PW'(delta);
    assign x_ext    = PW'(x_reg);
    assign y_ext    = PW'(y_reg);
    assign ang_full = rl_reg[34:8];
    assign head_wide = {heading_reg, 16'b0} >> AB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_gain_reg <= dod_pkg::TURN_GAIN_RESET;
            wb_op_reg     <= dod_pkg::OP_NONE;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                turn_gain_reg <= cfg_wr_data;
            wb_op_reg <= cmd.op;
            case (wb_op_reg)
                dod_pkg::OP_TH: heading_reg <= heading_reg + turns48[47 -: AB];
                dod_pkg::OP_XH: x_reg <= clamp_pos(x_sum);
                dod_pkg::OP_YH: y_reg <= clamp_pos(y_sum);
                default:        ;
            endcase
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            l_reg  <= left_speed;
            r_reg  <= right_speed;
            dt_reg <= tick_length;
        end
        prod_reg <= prod_next;
        case (wb_op_reg)
            dod_pkg::OP_DL: dl_reg   <= prod_reg[33:0];
            dod_pkg::OP_DR: dr_reg   <= prod_reg[33:0];
            dod_pkg::OP_RL: rl_reg   <= prod_reg[34:0];
            dod_pkg::OP_TG: turn_reg <= prod_reg[50:16];
            dod_pkg::OP_TL: acc_reg  <= dod_pkg::ACC_W'(prod_reg);
            dod_pkg::OP_XL: acc_reg  <= dod_pkg::ACC_W'(prod_reg);
            dod_pkg::OP_YL: acc_reg  <= dod_pkg::ACC_W'(prod_reg);
            default:        ;
        endcase
        if (cmd.load_out)
        begin
            pos_x        <= clamp_32(x_ext);
            pos_y        <= clamp_32(y_ext);
            heading      <= head_wide[15:0];
            linear_speed <= lr_sum[16:1];
            if (ang_full > ANG_MAX)
                angular_speed <= ANG_MAX[23:0];
            else if (ang_full < ANG_MIN)
                angular_speed <= ANG_MIN[23:0];
            else
                angular_speed <= ang_full[23:0];
        end
    end

    assign out_valid          = out_valid_reg;
    assign status.cordic_done = cordic_done;
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule

// ===== hdl/dod_ctrl.sv =====
// ----------------------------------------------------------------------------
// dod_ctrl
// sequencer that steps the datapath through its multiply schedule, waits
// on the cordic and hands the finished result to the output register
// ----------------------------------------------------------------------------
module dod_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dod_pkg::status_t  status,
    output dod_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [dod_pkg::IDX_W-1:0]   idx_reg, idx_next;
    dod_pkg::op_t                cur_op;
    logic                        hold;

    assign cur_op = dod_pkg::op_at(idx_reg);
    // position multiplies need the cordic result
    assign hold   = (cur_op == dod_pkg::OP_XL) && !status.cordic_done;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.op       = dod_pkg::OP_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (!hold)
                begin
                    cmd.op     = cur_op;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (idx_reg == dod_pkg::IDX_W'(dod_pkg::NUM_OPS - 1))
                    state_next = S_OUT;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== hdl/differential_drive_odometry_top.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// a tick is taken only while the sequencer is idle; the tick spacing is set
//   by the 16-step cordic and the four position multiplies that follow it
//   on the shared multiplier
// a finished result sits in the output register, so the next tick starts
//   while it waits for its transfer
// reset: asynchronous, active low; clears position and heading, loads the
//   turn gain with 811 (no clearing pass)
// ----------------------------------------------------------------------------
module differential_drive_odometry_top (
    input  logic                clk,
    input  logic                rst_n,
    // turn gain register write
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    // tick input
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  left_speed,
    input  logic signed [15:0]  right_speed,
    input  logic [15:0]         tick_length,
    // pose result
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic [15:0]         heading,
    output logic signed [15:0]  linear_speed,
    output logic signed [23:0]  angular_speed
);

    // command and status between sequencer and datapath
    dod_pkg::cmd_t     cmd;
    dod_pkg::status_t  status;

    // sequencer: accepts a tick, issues the multiply schedule (distances,
    // angular speed, turn, heading, then x and y once the cordic is done)
    dod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: pose state, cordic, shared multiplier, output register
    dod_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .left_speed    (left_speed),
        .right_speed   (right_speed),
        .tick_length   (tick_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading       (heading),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed)
    );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the differential drive odometry block against a cycle-free predictor
// of its fixed-point pose update (cordic heading, wrapping angle, saturating
// position and angular speed); directed corner ticks, random ticks under
// several turn gains, a long output hold-off and a drive into both position
// clamps, with random idling on both the tick and pose channels
// ----------------------------------------------------------------------------
module testbench;

    // predictor constants: q2.30 cordic gain, q32 reciprocal of two pi
    localparam longint CORDIC_GAIN    = 64'sd652032874;
    localparam longint INV_TWO_PI     = 64'sd683565276;
    localparam int     ATAN_STEPS     = 16;
    localparam logic [15:0] GAIN_AFTER_RESET = 16'd811;

    // 32-bit binary angle of atan(2^-i)
    localparam longint ATAN_TURNS [0:ATAN_STEPS-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    localparam int IDLE_PCT        = 19;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int RANDOM_PHASES   = 4;
    localparam int TICKS_PER_PHASE = 120;
    localparam int CLAMP_TICKS     = 760;

    // one pose as the block reports it
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        hd;
        logic signed [15:0] lin;
        logic signed [23:0] ang;
    } pose_t;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [15:0]        cfg_wr_data   = '0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic signed [15:0] left_speed    = '0;
    logic signed [15:0] right_speed   = '0;
    logic [15:0]        tick_length   = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] linear_speed;
    logic signed [23:0] angular_speed;

    // predictor state, mirrors the block's pose registers and turn gain
    longint                         odo_x;
    longint                         odo_y;
    logic [dod_pkg::ANGLE_BITS-1:0] odo_heading;
    logic [15:0]                    gain_now;

    // poses still owed by the block, oldest first
    pose_t pending_poses [$];

    // idling controls shared between the sender and the receiver
    bit in_gaps_on  = 1'b1;
    bit out_stalls_on = 1'b1;
    int hold_off_request = 0;

    // run bookkeeping
    int mismatches     = 0;
    int ticks_sent     = 0;
    int poses_checked  = 0;
    int gain_writes    = 0;
    int pos_clamp_hits = 0;
    int ang_clamp_hits = 0;

    differential_drive_odometry_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_speed    (left_speed),
        .right_speed   (right_speed),
        .tick_length   (tick_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading       (heading),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // cosine and sine of a heading, q2.30, sixteen rotations
    function automatic void heading_cos_sin(input logic [dod_pkg::ANGLE_BITS-1:0] hd,
                                            output longint c, output longint s);
        logic [31:0] ang32;
        int          ang_s;
        longint      z;
        longint      vx;
        longint      vy;
        longint      dx;
        longint      dy;
        bit          flip;
        ang32 = 32'(hd) << (32 - dod_pkg::ANGLE_BITS);
        ang_s = ang32;
        z     = ang_s;
        vx    = CORDIC_GAIN;
        vy    = 0;
        flip  = 1'b0;
        // fold the back half plane onto the front one, negate at the end
        if (z > (longint'(1) <<< 30))
        begin
            z    = z - (longint'(1) <<< 31);
            flip = 1'b1;
        end
        else if (z < -(longint'(1) <<< 30))
        begin
            z    = z + (longint'(1) <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < ATAN_STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (z >= 0)
            begin
                vx = vx - dx;
                vy = vy + dy;
                z  = z - ATAN_TURNS[i];
            end
            else
            begin
                vx = vx + dx;
                vy = vy - dy;
                z  = z + ATAN_TURNS[i];
            end
        end
        c = flip ? -vx : vx;
        s = flip ? -vy : vy;
    endfunction

    // advances the pose by one tick and returns what the block should report
    function automatic pose_t predict_pose(input logic [15:0] l_raw,
                                           input logic [15:0] r_raw,
                                           input logic [15:0] dt_raw);
        longint                         ls;
        longint                         rs;
        longint                         dtl;
        longint                         g;
        longint                         mean;
        longint                         c;
        longint                         s;
        longint                         nx;
        longint                         ny;
        longint                         turn;
        longint                         turns;
        longint                         w;
        logic [63:0]                    turns_u;
        logic [dod_pkg::ANGLE_BITS-1:0] dh;
        pose_t                          p;
        ls   = longint'(signed'(l_raw));
        rs   = longint'(signed'(r_raw));
        dtl  = longint'(dt_raw);
        g    = longint'(gain_now);
        mean = (ls * dtl + rs * dtl) >>> 1;

        // position moves along the heading held before this tick
        heading_cos_sin(odo_heading, c, s);
        nx = odo_x + ((mean * c) >>> 38);
        ny = odo_y + ((mean * s) >>> 38);
        odo_x = clamp_signed(nx, dod_pkg::POSITION_BITS);
        odo_y = clamp_signed(ny, dod_pkg::POSITION_BITS);
        if (odo_x != nx || odo_y != ny)
            pos_clamp_hits++;

        // turn in q16.16 radians, then turns in q.48, top bits wrap into heading
        turn    = ((rs * dtl - ls * dtl) * g) >>> 16;
        turns   = turn * INV_TWO_PI;
        turns_u = turns;
        dh      = dod_pkg::ANGLE_BITS'(turns_u >> (48 - dod_pkg::ANGLE_BITS));
        odo_heading = odo_heading + dh;

        p.x = 32'(clamp_signed(odo_x, 32));
        p.y = 32'(clamp_signed(odo_y, 32));
        if (dod_pkg::ANGLE_BITS >= 16)
            p.hd = 16'(odo_heading >> (dod_pkg::ANGLE_BITS - 16));
        else
            p.hd = 16'(odo_heading) << (16 - dod_pkg::ANGLE_BITS);
        p.lin = 16'((ls + rs) >>> 1);
        w     = ((rs - ls) * g) >>> 8;
        if (clamp_signed(w, 24) != w)
            ang_clamp_hits++;
        p.ang = 24'(clamp_signed(w, 24));
        return p;
    endfunction

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------

    function automatic void note_mismatch(input string field, input longint want,
                                          input longint got);
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    task automatic check_pose();
        pose_t want;
        if (pending_poses.size() == 0)
        begin
            mismatches++;
            $display("%0t: pose transfer with no tick outstanding, expected none "
                     , $time, "actual x %0d y %0d heading %0d", pos_x, pos_y, heading);
            return;
        end
        want = pending_poses.pop_front();
        poses_checked++;
        if (pos_x !== want.x)
            note_mismatch("pos_x", want.x, pos_x);
        if (pos_y !== want.y)
            note_mismatch("pos_y", want.y, pos_y);
        if (heading !== want.hd)
            note_mismatch("heading", want.hd, heading);
        if (linear_speed !== want.lin)
            note_mismatch("linear_speed", want.lin, linear_speed);
        if (angular_speed !== want.ang)
            note_mismatch("angular_speed", want.ang, angular_speed);
    endtask

    // samples the pose channel at each edge, then picks next cycle's ready;
    // a hold-off request is counted down here, one cycle at a time
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_pose();
            if (hold_off_request > 0)
            begin
                hold_left        = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= !(out_stalls_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ends the run if neither channel moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d poses outstanding",
                         $time, quiet, pending_poses.size());
                $display("differential_drive_odometry_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offers one tick, holding valid and payload until the transfer; valid is
    // left high afterwards, so back-to-back ticks keep it asserted throughout
    task automatic send_tick(input logic [15:0] l, input logic [15:0] r,
                             input logic [15:0] dt);
        while (in_gaps_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        left_speed  <= l;
        right_speed <= r;
        tick_length <= dt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_poses.push_back(predict_pose(l, r, dt));
        ticks_sent++;
    endtask

    // drops valid and waits for every owed pose; the block is then idle
    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_turn_gain(input logic [15:0] g);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        gain_now  = g;
        gain_writes++;
    endtask

    // random tick with a mix of shapes: raw bits, realistic small motion,
    // zero elapsed time, field extremes and turning on the spot
    task automatic random_tick(output logic [15:0] l, output logic [15:0] r,
                               output logic [15:0] dt);
        logic [15:0] corners [5];
        corners = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        l  = 16'($urandom);
        r  = 16'($urandom);
        dt = 16'($urandom);
        case ($urandom_range(0, 9))
            5, 6:
            begin
                l  = 16'($urandom_range(0, 1023)) - 16'd512;
                r  = l + 16'($urandom_range(0, 127)) - 16'd64;
                dt = 16'($urandom_range(0, 6554));
            end
            7:
                dt = '0;
            8:
            begin
                l  = corners[$urandom_range(0, 4)];
                r  = corners[$urandom_range(0, 4)];
                dt = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
            end
            9:
                r = -l;
            default:
                ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corner ticks under the reset gain, full gain and zero gain
    task automatic test_directed_corners();
        // reset gain: extremes of every field, zero tick, mean flooring
        send_tick(16'd0, 16'd0, 16'd0);
        send_tick(16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_tick(16'h8000, 16'h8000, 16'hFFFF);
        send_tick(16'h7FFF, 16'h8000, 16'hFFFF);
        send_tick(16'h8000, 16'h7FFF, 16'hFFFF);
        send_tick(16'd1000, -16'sd1000, 16'd0);
        send_tick(16'hFFFF, 16'd0, 16'd1);
        send_tick(16'd1, 16'd0, 16'd1);
        send_tick(16'h5555, 16'hAAAA, 16'h5555);
        send_tick(16'hAAAA, 16'h5555, 16'hAAAA);
        send_tick(16'd256, 16'd512, 16'd6554);
        send_tick(-16'sd300, 16'd300, 16'd3277);
        drain_ticks();

        // full gain drives angular speed into both clamps
        write_turn_gain(16'hFFFF);
        send_tick(16'h7FFF, 16'h8000, 16'hFFFF);
        send_tick(16'h8000, 16'h7FFF, 16'hFFFF);
        send_tick(16'h8000, 16'h7FFF, 16'd0);
        send_tick(16'd100, -16'sd100, 16'd1);
        drain_ticks();

        // zero gain: no turn whatever the speed difference
        write_turn_gain(16'd0);
        send_tick(16'h8000, 16'h7FFF, 16'hFFFF);
        send_tick(16'd500, 16'd700, 16'd20000);
        drain_ticks();
    endtask

    // random ticks across several gains; the second phase runs with no idling
    task automatic test_random_ticks();
        logic [15:0] phase_gain [RANDOM_PHASES];
        logic [15:0] l;
        logic [15:0] r;
        logic [15:0] dt;
        phase_gain = '{16'($urandom_range(2, 65534)), 16'd1, GAIN_AFTER_RESET,
                       16'($urandom_range(0, 2047))};
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_turn_gain(phase_gain[ph]);
            in_gaps_on    = (ph != 1);
            out_stalls_on = (ph != 1);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                random_tick(l, r, dt);
                send_tick(l, r, dt);
            end
            drain_ticks();
        end
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    // pose channel held off while ticks keep coming, so the block backs up
    // and stalls its tick input
    task automatic test_output_hold_off();
        logic [15:0] l;
        logic [15:0] r;
        logic [15:0] dt;
        in_gaps_on       = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        for (int n = 0; n < 24; n++)
        begin
            random_tick(l, r, dt);
            send_tick(l, r, dt);
        end
        drain_ticks();
        in_gaps_on = 1'b1;
    endtask

    // straight runs at full speed and full tick length; the major axis gains at
    // least 5.9 million a tick, enough to hit one clamp and then the other
    task automatic test_position_clamp();
        write_turn_gain(16'($urandom));
        for (int n = 0; n < CLAMP_TICKS; n++)
            send_tick(16'h7FFF, 16'h7FFF, 16'hFFFF);
        for (int n = 0; n < CLAMP_TICKS; n++)
            send_tick(16'h8000, 16'h8000, 16'hFFFF);
        drain_ticks();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        odo_x       = 0;
        odo_y       = 0;
        odo_heading = '0;
        gain_now    = GAIN_AFTER_RESET;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_ticks();
        test_output_hold_off();
        test_position_clamp();

        // let any stray pose show up before closing
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("run: %0d ticks, %0d poses checked, %0d turn gain writes",
                 ticks_sent, poses_checked, gain_writes);
        $display("run: position clamped on %0d ticks, angular speed on %0d",
                 pos_clamp_hits, ang_clamp_hits);
        if (mismatches == 0 && pending_poses.size() == 0)
            $display("differential_drive_odometry_top: match");
        else
            $display("differential_drive_odometry_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dod_pkg.sv
hdl/dod_cordic.sv
hdl/dod_datapath.sv
hdl/dod_ctrl.sv
hdl/differential_drive_odometry_top.sv
dv/testbench.sv
